>>> rtl/core/cartridge_bank_mapper_top_assert.svh
// assertion macros for the cartridge bank mapper checker
// expects signals named clock and reset in the scope where a macro is used
`ifndef CARTRIDGE_BANK_MAPPER_TOP_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define CBM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/cbm_pkg.sv
// shared types and constants of the cartridge bank mapper
// no dependencies
package cbm_pkg;

   localparam int unsigned MAX_ROM_BANKS = 512;
   localparam int unsigned MAX_RAM_BANKS = 4;
   localparam int unsigned MIN_ROM_BANKS = 2;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned PHYS_W      = 23;
   localparam int unsigned TARGET_W    = 2;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned ROM_CNT_W   = 10;
   localparam int unsigned RAM_CNT_W   = 3;
   localparam int unsigned ROM_BANK_W  = 7;
   localparam int unsigned RAM_BANK_W  = 2;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam int unsigned DIV_CNT_W   = 3;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MBC1 = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MBC2 = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MBC3 = 2'd3;

   localparam logic [TARGET_W-1:0] TARGET_NONE = 2'd0;
   localparam logic [TARGET_W-1:0] TARGET_ROM  = 2'd1;
   localparam logic [TARGET_W-1:0] TARGET_RAM  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAPPER_KIND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_BANKS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_BANKS   = 2'd2;

   localparam logic [DATA_W-1:0]     RAM_ENABLE_KEY = 8'h0A;
   localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 7'd1;
   localparam logic [DIV_CNT_W-1:0]  DIV_LAST_BIT   = DIV_CNT_W'(ROM_BANK_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE
   } cbm_state_type;

   typedef struct packed {
      logic load_item;
      logic decode;
      logic div_step;
   } cbm_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_last;
   } cbm_status_type;

endpackage

>>> rtl/core/cbm_ctrl.sv
// control state machine of the cartridge bank mapper
// depends on cbm_pkg
module cbm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  cbm_pkg::cbm_status_type status,
   output cbm_pkg::cbm_cmd_type    cmd,
   output logic                    busy
);
   import cbm_pkg::*;

   cbm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = status.need_div ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy          = 1'b0;
            cmd.load_item = start;
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

>>> rtl/core/cbm_dp.sv
// datapath of the cartridge bank mapper: config and bank registers,
// address decode and the bit-serial rom bank reduction; depends on cbm_pkg
module cbm_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  cbm_pkg::cbm_cmd_type             cmd,
   output cbm_pkg::cbm_status_type          status,
   input  logic                             csr_write,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_operation,
   input  logic [cbm_pkg::ADDR_W-1:0]       req_address,
   input  logic [cbm_pkg::DATA_W-1:0]       req_write_value,
   output logic                             rsp_valid,
   output logic [cbm_pkg::TARGET_W-1:0]     rsp_target,
   output logic [cbm_pkg::PHYS_W-1:0]       rsp_phys_address,
   output logic                             rsp_ram_write
);
   import cbm_pkg::*;

   // configuration
   logic [KIND_W-1:0]    kind_ff;
   logic [ROM_CNT_W-1:0] rom_banks_ff;
   logic [RAM_CNT_W-1:0] ram_banks_ff;

   // bank state
   logic [ROM_BANK_W-1:0] rom_sel_ff;
   logic [RAM_BANK_W-1:0] ram_sel_ff;
   logic                  mode_ff;
   logic                  ram_en_ff;

   // captured item
   logic                  op_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [DATA_W-1:0]     wval_ff;

   // result registers
   logic                  rsp_valid_ff;
   logic [TARGET_W-1:0]   target_ff;
   logic [PHYS_W-1:0]     phys_ff;
   logic                  ram_write_ff;

   // divider
   logic [ROM_BANK_W-1:0] div_num_ff;
   logic [ROM_BANK_W-1:0] div_rem_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;

   logic [ROM_CNT_W-1:0]  rom_mod;
   logic [RAM_CNT_W-1:0]  ram_mod;

   logic [TARGET_W-1:0]   target_in;
   logic [PHYS_W-1:0]     phys_in;
   logic                  ram_write_in;
   logic                  rom_store;
   logic [ROM_BANK_W-1:0] rom_n;
   logic                  ram_store;
   logic [RAM_BANK_W-1:0] ram_n;
   logic [RAM_BANK_W-1:0] ram_sel_in;
   logic                  ram_en_wr;
   logic                  mode_wr;
   logic                  key_hit;
   logic                  is_rom;
   logic                  is_ram;
   logic                  mapped_write;
   logic [1:0]            region;

   logic [ROM_BANK_W:0]   trial;
   logic [ROM_CNT_W-1:0]  diff;
   logic                  trial_ge;
   logic [ROM_BANK_W-1:0] rem_in;

   // clamp of the bank counts
   always_comb begin
      if (rom_banks_ff < ROM_CNT_W'(MIN_ROM_BANKS)) begin
         rom_mod = ROM_CNT_W'(MIN_ROM_BANKS);
      end else if (rom_banks_ff > ROM_CNT_W'(MAX_ROM_BANKS)) begin
         rom_mod = ROM_CNT_W'(MAX_ROM_BANKS);
      end else begin
         rom_mod = rom_banks_ff;
      end
      ram_mod = (ram_banks_ff > RAM_CNT_W'(MAX_RAM_BANKS)) ?
                RAM_CNT_W'(MAX_RAM_BANKS) : ram_banks_ff;
   end

   // ram bank reduction, the numerator stays below four
   always_comb begin
      case (ram_mod)
         3'd1:    ram_sel_in = '0;
         3'd2:    ram_sel_in = {1'b0, ram_n[0]};
         3'd3:    ram_sel_in = (ram_n == 2'd3) ? 2'd0 : ram_n;
         default: ram_sel_in = ram_n;
      endcase
   end

   // decode of the captured item
   always_comb begin
      is_rom       = !addr_ff[15];
      is_ram       = (addr_ff[15:13] == 3'b101);
      region       = addr_ff[14:13];
      key_hit      = (wval_ff == RAM_ENABLE_KEY);
      mapped_write = op_ff && is_rom;

      target_in    = TARGET_NONE;
      phys_in      = '0;
      ram_write_in = 1'b0;
      if (is_rom && !op_ff) begin
         target_in = TARGET_ROM;
         if (kind_ff == KIND_NONE || !addr_ff[14]) begin
            phys_in = PHYS_W'(addr_ff);
         end else begin
            phys_in = PHYS_W'({rom_sel_ff, addr_ff[13:0]});
         end
      end else if (is_ram) begin
         target_in    = TARGET_RAM;
         phys_in      = PHYS_W'({ram_sel_ff, addr_ff[12:0]});
         ram_write_in = op_ff && (kind_ff == KIND_NONE || ram_en_ff);
      end

      rom_store = 1'b0;
      rom_n     = '0;
      ram_store = 1'b0;
      ram_n     = '0;
      ram_en_wr = 1'b0;
      mode_wr   = 1'b0;
      if (mapped_write) begin
         case (kind_ff)
            KIND_MBC1: begin
               case (region)
                  2'd0: ram_en_wr = 1'b1;
                  2'd1: begin
                     rom_store = 1'b1;
                     rom_n     = {rom_sel_ff[6:5], wval_ff[4:0]};
                     if (wval_ff[4:0] == 5'd0) rom_n[0] = 1'b1;
                  end
                  2'd2: begin
                     if (!mode_ff) begin
                        rom_store = 1'b1;
                        rom_n     = {wval_ff[1:0], rom_sel_ff[4:0]};
                     end else begin
                        ram_store = 1'b1;
                        ram_n     = wval_ff[1:0];
                     end
                  end
                  default: mode_wr = 1'b1;
               endcase
            end
            KIND_MBC2: begin
               if (region == 2'd0 && !addr_ff[8]) ram_en_wr = 1'b1;
               if (region == 2'd1 && addr_ff[8]) begin
                  rom_store = 1'b1;
                  rom_n     = {3'b000, wval_ff[3:0]};
               end
            end
            KIND_MBC3: begin
               case (region)
                  2'd0: ram_en_wr = 1'b1;
                  2'd1: begin
                     rom_store = 1'b1;
                     rom_n     = wval_ff[6:0];
                     if (wval_ff[6:0] == 7'd0) rom_n = 7'd1;
                  end
                  2'd2: begin
                     ram_store = 1'b1;
                     ram_n     = wval_ff[1:0];
                  end
                  default: ram_store = 1'b0;
               endcase
            end
            default: rom_store = 1'b0;
         endcase
      end
   end

   // one restoring step per cycle, the remainder never exceeds the numerator
   always_comb begin
      trial    = {div_rem_ff, div_num_ff[ROM_BANK_W-1]};
      trial_ge = (ROM_CNT_W'(trial) >= rom_mod);
      diff     = ROM_CNT_W'(trial) - rom_mod;
      rem_in   = trial_ge ? diff[ROM_BANK_W-1:0] : trial[ROM_BANK_W-1:0];
   end

   assign status.need_div = rom_store;
   assign status.div_last = (div_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_NONE;
         rom_banks_ff <= ROM_CNT_W'(MIN_ROM_BANKS);
         ram_banks_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAPPER_KIND: kind_ff      <= csr_wdata[KIND_W-1:0];
            CSR_ROM_BANKS:   rom_banks_ff <= csr_wdata[ROM_CNT_W-1:0];
            CSR_RAM_BANKS:   ram_banks_ff <= csr_wdata[RAM_CNT_W-1:0];
            default:         kind_ff      <= kind_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_sel_ff   <= ROM_BANK_RESET;
         ram_sel_ff   <= '0;
         mode_ff      <= 1'b0;
         ram_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.decode;
         if (cmd.decode) begin
            if (ram_en_wr) ram_en_ff <= key_hit;
            if (mode_wr) mode_ff <= wval_ff[0];
            if (ram_store && ram_mod != '0) ram_sel_ff <= ram_sel_in;
         end
         if (cmd.div_step && status.div_last) rom_sel_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_operation;
         addr_ff <= req_address;
         wval_ff <= req_write_value;
      end
      if (cmd.decode) begin
         target_ff    <= target_in;
         phys_ff      <= phys_in;
         ram_write_ff <= ram_write_in;
         div_num_ff   <= rom_n;
         div_rem_ff   <= '0;
         div_cnt_ff   <= DIV_LAST_BIT;
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[ROM_BANK_W-2:0], 1'b0};
         div_rem_ff <= rem_in;
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target       = target_ff;
   assign rsp_phys_address = phys_ff;
   assign rsp_ram_write    = ram_write_ff;

endmodule

>>> rtl/core/cartridge_bank_mapper_top.sv
// top level of the cartridge bank mapper
// depends on cbm_pkg, cbm_ctrl and cbm_dp
//
// Translates CPU bus accesses into cartridge ROM or save-RAM byte addresses
// and keeps the bank registers of the selected mapper kind.
// Item channel: an item is taken when start is high and busy is low.
// Result channel: rsp_valid is high for one cycle with target, physical
// address and ram write flag; the receiver cannot hold it off.
// The item is captured, decoded and its result registered. Items do not
// overlap: busy is high during decode, and a write that loads a rom bank
// keeps it high through the divide state, one bank number bit per cycle,
// in the bit-serial remainder unit reducing it modulo the rom bank count.
// Config channel: csr_valid with csr_index and csr_wdata, always ready;
// write only while busy is low and no result is pending.
// Reset: synchronous; no mapper, 2 rom banks, no ram banks, rom bank 1,
// ram bank 0, rom banking mode, ram disabled.
module cartridge_bank_mapper_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [cbm_pkg::ADDR_W-1:0]       req_address,
   input  logic [cbm_pkg::DATA_W-1:0]       req_write_value,
   output logic                             rsp_valid,
   output logic [cbm_pkg::TARGET_W-1:0]     rsp_target,
   output logic [cbm_pkg::PHYS_W-1:0]       rsp_phys_address,
   output logic                             rsp_ram_write,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cbm_pkg::*;

   cbm_cmd_type    cmd;
   cbm_status_type status;
   logic           csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   cbm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   cbm_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_operation    (req_operation),
      .req_address      (req_address),
      .req_write_value  (req_write_value),
      .rsp_valid        (rsp_valid),
      .rsp_target       (rsp_target),
      .rsp_phys_address (rsp_phys_address),
      .rsp_ram_write    (rsp_ram_write)
   );

endmodule

>>> rtl/core/cbm_checker.sv
// port-level checker of the cartridge bank mapper, bound to the top level
// depends on cbm_pkg and cartridge_bank_mapper_top_assert.svh
`include "cartridge_bank_mapper_top_assert.svh"

module cbm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [cbm_pkg::TARGET_W-1:0]     rsp_target,
   input logic [cbm_pkg::PHYS_W-1:0]       rsp_phys_address,
   input logic                             rsp_ram_write
);
   import cbm_pkg::*;

   logic accepted;

   assign accepted = start && !busy;

   `CBM_ASSERT_NEXT(a_busy_after_accept, accepted, busy, "no busy after item taken")
   `CBM_ASSERT_NEXT(a_result_follows, accepted, ##1 rsp_valid, "result missing after item")
   `CBM_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `CBM_ASSERT_SAME(a_none_is_clean, rsp_valid && rsp_target == TARGET_NONE, rsp_phys_address == '0 && !rsp_ram_write, "no-access result carries data")
   `CBM_ASSERT_SAME(a_write_is_ram, rsp_valid && rsp_ram_write, rsp_target == TARGET_RAM, "ram write outside save ram")

endmodule

bind cartridge_bank_mapper_top cbm_checker u_cbm_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_target       (rsp_target),
   .rsp_phys_address (rsp_phys_address),
   .rsp_ram_write    (rsp_ram_write)
);
